[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[src/e2c_pkg.sv]
`timescale 1ns / 1ps

package e2c_pkg;

    localparam int SECONDS_W = 32;
    localparam int DIVISOR_W = 6;
    localparam int PC_W      = 4;

    localparam logic [DIVISOR_W-1:0] DIVISOR_MIN  = 6'd60;
    localparam logic [DIVISOR_W-1:0] DIVISOR_HOUR = 6'd24;
    localparam logic [DIVISOR_W-1:0] DIVISOR_WEEK = 6'd7;

    // one byte step of the divider: q = (v * RECIP) >> RECIP_SHIFT,
    // exact for every partial value v below 256 times the divisor
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 20;
    localparam logic [RECIP_W-1:0] RECIP_MIN  = 18'd17477;
    localparam logic [RECIP_W-1:0] RECIP_HOUR = 18'd43691;
    localparam logic [RECIP_W-1:0] RECIP_WEEK = 18'd149797;

    // 1970-01-01 was a thursday
    localparam logic [2:0] WEEK_OFFSET = 3'd4;

    localparam logic signed [7:0] YEAR_1970 = -8'sd30;
    localparam logic [1:0] MOD4_1970   = 2'd2;
    localparam logic [6:0] MOD100_1970 = 7'd70;
    localparam logic [8:0] MOD400_1970 = 9'd370;
    localparam logic [6:0] MOD100_LAST = 7'd99;
    localparam logic [8:0] MOD400_LAST = 9'd399;

    localparam logic [8:0] LEN_YEAR = 9'd365;
    localparam logic [8:0] LEN_LEAP = 9'd366;
    localparam logic [4:0] LEN_FEB_LEAP = 5'd29;
    localparam logic [4:0] LEN_MONTH_MAX = 5'd31;
    localparam logic [3:0] MON_FEB  = 4'd1;
    localparam logic [3:0] MON_LAST = 4'd11;

    typedef enum logic [3:0] {
        OP_IDLE   = 4'd0,
        OP_DIV60  = 4'd1,
        OP_WB_SEC = 4'd2,
        OP_WB_MIN = 4'd3,
        OP_DIV24  = 4'd4,
        OP_WB_HR  = 4'd5,
        OP_DIV7   = 4'd6,
        OP_WB_WD  = 4'd7,
        OP_YEAR   = 4'd8,
        OP_MON    = 4'd9,
        OP_EMIT   = 4'd10
    } op_t;

    typedef enum logic [1:0] {
        C_NEXT   = 2'd0,
        C_ALWAYS = 2'd1,
        C_YEAR   = 2'd2,
        C_MON    = 2'd3
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ctrl_t;

    typedef struct packed {
        logic [5:0]        second_of_minute;
        logic [5:0]        minute_of_hour;
        logic [4:0]        hour_of_day;
        logic [2:0]        weekday;
        logic signed [7:0] year_from_2000;
        logic [8:0]        day_of_year;
        logic [3:0]        month_index;
        logic [4:0]        day_of_month;
    } result_t;

    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w.op     = OP_IDLE;
        w.cond   = C_NEXT;
        w.target = '0;
        case (pc)
            4'd0:  w.op = OP_IDLE;
            4'd1:  w.op = OP_DIV60;
            4'd2:  w.op = OP_WB_SEC;
            4'd3:  w.op = OP_DIV60;
            4'd4:  w.op = OP_WB_MIN;
            4'd5:  w.op = OP_DIV24;
            4'd6:  w.op = OP_WB_HR;
            4'd7:  w.op = OP_DIV7;
            4'd8:  w.op = OP_WB_WD;
            4'd9:
            begin
                w.op     = OP_YEAR;
                w.cond   = C_YEAR;
                w.target = 4'd9;
            end
            4'd10:
            begin
                w.op     = OP_MON;
                w.cond   = C_MON;
                w.target = 4'd10;
            end
            4'd11:
            begin
                w.op     = OP_EMIT;
                w.cond   = C_ALWAYS;
                w.target = 4'd0;
            end
            default:
            begin
                w.op     = OP_IDLE;
                w.cond   = C_ALWAYS;
                w.target = 4'd0;
            end
        endcase
        return w;
    endfunction

    // february gives the common-year length, leap fixup is done by the caller
    function automatic logic [4:0] month_days(input logic [3:0] mon);
        logic [4:0] d;
        case (mon)
            4'd1:  d = 5'd28;
            4'd3:  d = 5'd30;
            4'd5:  d = 5'd30;
            4'd8:  d = 5'd30;
            4'd10: d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

[src/e2c_in_if.sv]
`timescale 1ns / 1ps

interface e2c_in_if;
    logic                           valid;
    logic                           ready;
    logic [e2c_pkg::SECONDS_W-1:0]  epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink (input valid, input epoch_seconds, output ready);
endinterface

[src/e2c_out_if.sv]
`timescale 1ns / 1ps

interface e2c_out_if;
    logic              valid;
    logic              ready;
    logic [5:0]        second_of_minute;
    logic [5:0]        minute_of_hour;
    logic [4:0]        hour_of_day;
    logic [2:0]        weekday;
    logic signed [7:0] year_from_2000;
    logic [8:0]        day_of_year;
    logic [3:0]        month_index;
    logic [4:0]        day_of_month;

    modport source (
        output valid, output second_of_minute, output minute_of_hour,
        output hour_of_day, output weekday, output year_from_2000,
        output day_of_year, output month_index, output day_of_month,
        input ready
    );
    modport sink (
        input valid, input second_of_minute, input minute_of_hour,
        input hour_of_day, input weekday, input year_from_2000,
        input day_of_year, input month_index, input day_of_month,
        output ready
    );
endinterface

[src/e2c_div.sv]
`timescale 1ns / 1ps

// divider by one of the small fixed divisors, one quotient byte per cycle;
// each byte step divides the partial value by reciprocal multiplication
module e2c_div #(
    parameter int W = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [W-1:0]                    dividend,
    input  logic [e2c_pkg::DIVISOR_W-1:0]   divisor,
    output logic                            busy,
    output logic [W-1:0]                    quotient,
    output logic [e2c_pkg::DIVISOR_W-1:0]   remainder
);

    localparam int NB     = (W + 7) / 8;
    localparam int PW     = NB * 8;
    localparam int CNT_W  = $clog2(NB + 1);
    localparam int PART_W = e2c_pkg::DIVISOR_W + 8;
    localparam int PROD_W = PART_W + e2c_pkg::RECIP_W;

    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [PW-1:0]                     q_reg, q_next;
    logic [e2c_pkg::DIVISOR_W-1:0]     r_reg, r_next;
    logic [e2c_pkg::DIVISOR_W-1:0]     d_reg, d_next;
    logic [PART_W-1:0]                 part;
    logic [e2c_pkg::RECIP_W-1:0]       recip;
    logic [PROD_W-1:0]                 prod;
    logic [7:0]                        digit;
    logic [PART_W-1:0]                 back;
    logic [PART_W-1:0]                 left;

    always_comb
    begin
        case (d_reg)
            e2c_pkg::DIVISOR_HOUR: recip = e2c_pkg::RECIP_HOUR;
            e2c_pkg::DIVISOR_WEEK: recip = e2c_pkg::RECIP_WEEK;
            default:               recip = e2c_pkg::RECIP_MIN;
        endcase
    end

    // partial remainder stays below the divisor, so the byte quotient fits in 8 bits
    assign part  = {r_reg, q_reg[PW-1 -: 8]};
    assign prod  = part * recip;
    assign digit = prod[e2c_pkg::RECIP_SHIFT +: 8];
    assign back  = digit * d_reg;
    assign left  = part - back;

    always_comb
    begin
        cnt_next = cnt_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        if (start)
        begin
            cnt_next = CNT_W'(NB);
            q_next   = PW'(dividend);
            r_next   = '0;
            d_next   = divisor;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            q_next   = {q_reg[PW-9:0], digit};
            r_next   = left[e2c_pkg::DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy      = cnt_reg != '0;
    assign quotient  = q_reg[W-1:0];
    assign remainder = r_reg;

endmodule

[src/epoch_to_calendar.sv]
`timescale 1ns / 1ps
// accept to result valid: divisions by 60, 60, 24 and 7 in the byte-per-cycle
// divider, then a loop of one year per step from 1970, one of one month per step,
// and the emit; one transaction at a time, the next taken once back at idle;
// a result still waiting on the output holds the final step
// reset: asynchronous, active low; clears step counter, divider count, valid flag
`include "assert_macros.svh"

module epoch_to_calendar #(
    parameter int EPOCH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    e2c_in_if.sink      epoch,
    e2c_out_if.source   calendar
);

    // 86400 seconds a day exceeds 2^16, so days fit in this many bits
    localparam int DAY_BITS = EPOCH_BITS - 16;

    e2c_pkg::ctrl_t                  ctrl;
    logic [e2c_pkg::PC_W-1:0]        pc_reg, pc_next;
    logic                            out_valid_reg, out_valid_next;
    e2c_pkg::result_t                out_data_reg, out_data_next;

    logic [EPOCH_BITS-1:0]           t_reg, t_next;
    logic [DAY_BITS-1:0]             rem_reg, rem_next;
    logic signed [7:0]               year_reg, year_next;
    logic [1:0]                      m4_reg, m4_next;
    logic [6:0]                      m100_reg, m100_next;
    logic [8:0]                      m400_reg, m400_next;
    logic [3:0]                      mon_reg, mon_next;
    logic [8:0]                      yday_reg, yday_next;
    logic [5:0]                      sec_reg, sec_next;
    logic [5:0]                      min_reg, min_next;
    logic [4:0]                      hour_reg, hour_next;
    logic [2:0]                      wday_reg, wday_next;

    logic                            stall;
    logic                            take;
    logic                            leap;
    logic [8:0]                      ylen;
    logic [4:0]                      mlen;

    logic                            div_start;
    logic                            div_busy;
    logic [EPOCH_BITS-1:0]           div_dividend;
    logic [e2c_pkg::DIVISOR_W-1:0]   div_divisor;
    logic [EPOCH_BITS-1:0]           div_q;
    logic [e2c_pkg::DIVISOR_W-1:0]   div_r;

    assign ctrl = e2c_pkg::ucode(pc_reg);

    assign leap = ((m4_reg == 2'd0) && (m100_reg != 7'd0)) || (m400_reg == 9'd0);
    assign ylen = leap ? e2c_pkg::LEN_LEAP : e2c_pkg::LEN_YEAR;
    assign mlen = (leap && (mon_reg == e2c_pkg::MON_FEB)) ? e2c_pkg::LEN_FEB_LEAP
                                                          : e2c_pkg::month_days(mon_reg);

    assign div_start = (ctrl.op == e2c_pkg::OP_DIV60) || (ctrl.op == e2c_pkg::OP_DIV24)
                    || (ctrl.op == e2c_pkg::OP_DIV7);
    assign div_dividend = (ctrl.op == e2c_pkg::OP_DIV7)
                        ? t_reg + EPOCH_BITS'(e2c_pkg::WEEK_OFFSET) : t_reg;

    always_comb
    begin
        case (ctrl.op)
            e2c_pkg::OP_DIV24: div_divisor = e2c_pkg::DIVISOR_HOUR;
            e2c_pkg::OP_DIV7:  div_divisor = e2c_pkg::DIVISOR_WEEK;
            default:           div_divisor = e2c_pkg::DIVISOR_MIN;
        endcase
    end

    e2c_div #(
        .W (EPOCH_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // steps that wait on the input, the divider or the output register
    always_comb
    begin
        case (ctrl.op)
            e2c_pkg::OP_IDLE:   stall = !epoch.valid;
            e2c_pkg::OP_WB_SEC: stall = div_busy;
            e2c_pkg::OP_WB_MIN: stall = div_busy;
            e2c_pkg::OP_WB_HR:  stall = div_busy;
            e2c_pkg::OP_WB_WD:  stall = div_busy;
            e2c_pkg::OP_EMIT:   stall = out_valid_reg && !calendar.ready;
            default:            stall = 1'b0;
        endcase
    end

    always_comb
    begin
        case (ctrl.cond)
            e2c_pkg::C_ALWAYS: take = 1'b1;
            e2c_pkg::C_YEAR:   take = rem_reg >= DAY_BITS'(ylen);
            e2c_pkg::C_MON:    take = (mon_reg != e2c_pkg::MON_LAST)
                                   && (rem_reg >= DAY_BITS'(mlen));
            default:           take = 1'b0;
        endcase
    end

    assign pc_next = stall ? pc_reg
                   : (take ? ctrl.target : pc_reg + e2c_pkg::PC_W'(1));

    always_comb
    begin
        t_next         = t_reg;
        rem_next       = rem_reg;
        year_next      = year_reg;
        m4_next        = m4_reg;
        m100_next      = m100_reg;
        m400_next      = m400_reg;
        mon_next       = mon_reg;
        yday_next      = yday_reg;
        sec_next       = sec_reg;
        min_next       = min_reg;
        hour_next      = hour_reg;
        wday_next      = wday_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !calendar.ready;
        case (ctrl.op)
            e2c_pkg::OP_IDLE:
            begin
                if (epoch.valid)
                begin
                    t_next    = EPOCH_BITS'(epoch.epoch_seconds);
                    year_next = e2c_pkg::YEAR_1970;
                    m4_next   = e2c_pkg::MOD4_1970;
                    m100_next = e2c_pkg::MOD100_1970;
                    m400_next = e2c_pkg::MOD400_1970;
                    mon_next  = '0;
                end
            end
            e2c_pkg::OP_WB_SEC:
            begin
                if (!div_busy)
                begin
                    t_next   = div_q;
                    sec_next = div_r;
                end
            end
            e2c_pkg::OP_WB_MIN:
            begin
                if (!div_busy)
                begin
                    t_next   = div_q;
                    min_next = div_r;
                end
            end
            e2c_pkg::OP_WB_HR:
            begin
                if (!div_busy)
                begin
                    t_next    = div_q;
                    rem_next  = div_q[DAY_BITS-1:0];
                    hour_next = div_r[4:0];
                end
            end
            e2c_pkg::OP_WB_WD:
            begin
                if (!div_busy)
                begin
                    wday_next = div_r[2:0];
                end
            end
            e2c_pkg::OP_YEAR:
            begin
                if (take)
                begin
                    rem_next  = rem_reg - DAY_BITS'(ylen);
                    year_next = year_reg + 8'sd1;
                    m4_next   = m4_reg + 2'd1;
                    m100_next = (m100_reg == e2c_pkg::MOD100_LAST) ? 7'd0 : m100_reg + 7'd1;
                    m400_next = (m400_reg == e2c_pkg::MOD400_LAST) ? 9'd0 : m400_reg + 9'd1;
                end
                else
                begin
                    yday_next = rem_reg[8:0];
                end
            end
            e2c_pkg::OP_MON:
            begin
                if (take)
                begin
                    rem_next = rem_reg - DAY_BITS'(mlen);
                    mon_next = mon_reg + 4'd1;
                end
            end
            e2c_pkg::OP_EMIT:
            begin
                if (!stall)
                begin
                    out_valid_next                 = 1'b1;
                    out_data_next.second_of_minute = sec_reg;
                    out_data_next.minute_of_hour   = min_reg;
                    out_data_next.hour_of_day      = hour_reg;
                    out_data_next.weekday          = wday_reg;
                    out_data_next.year_from_2000   = year_reg;
                    out_data_next.day_of_year      = yday_reg;
                    out_data_next.month_index      = mon_reg;
                    out_data_next.day_of_month     = rem_reg[4:0] + 5'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        rem_reg      <= rem_next;
        year_reg     <= year_next;
        m4_reg       <= m4_next;
        m100_reg     <= m100_next;
        m400_reg     <= m400_next;
        mon_reg      <= mon_next;
        yday_reg     <= yday_next;
        sec_reg      <= sec_next;
        min_reg      <= min_next;
        hour_reg     <= hour_next;
        wday_reg     <= wday_next;
        out_data_reg <= out_data_next;
    end

    assign epoch.ready               = ctrl.op == e2c_pkg::OP_IDLE;
    assign calendar.valid            = out_valid_reg;
    assign calendar.second_of_minute = out_data_reg.second_of_minute;
    assign calendar.minute_of_hour   = out_data_reg.minute_of_hour;
    assign calendar.hour_of_day      = out_data_reg.hour_of_day;
    assign calendar.weekday          = out_data_reg.weekday;
    assign calendar.year_from_2000   = out_data_reg.year_from_2000;
    assign calendar.day_of_year      = out_data_reg.day_of_year;
    assign calendar.month_index      = out_data_reg.month_index;
    assign calendar.day_of_month     = out_data_reg.day_of_month;

    // the divider only runs while the program sits on a writeback step
    `ASSERT_IMP(a_div_busy_at_wb, div_busy,
        (ctrl.op == e2c_pkg::OP_WB_SEC) || (ctrl.op == e2c_pkg::OP_WB_MIN) ||
        (ctrl.op == e2c_pkg::OP_WB_HR) || (ctrl.op == e2c_pkg::OP_WB_WD))
    `ASSERT_NXT(a_emit_sets_valid, (ctrl.op == e2c_pkg::OP_EMIT) && !stall,
        calendar.valid && (pc_reg == '0))
    `ASSERT_IMP(a_month_exit_in_range, (ctrl.op == e2c_pkg::OP_MON) && !take,
        rem_reg < DAY_BITS'(e2c_pkg::LEN_MONTH_MAX))
    `ASSERT_IMP(a_no_accept_while_busy, epoch.valid && epoch.ready, !div_busy)

endmodule
